FILE: rtl/core/asvr_pkg.sv
// Shared types and constants for the ratiometric converter scan block.
// No dependencies; imported by asvr_div, adc_scan_vref_ratiometric_top and its testbench.
package asvr_pkg;

  localparam int MODE_BITS   = 2;
  localparam int KIND_BITS   = 2;
  localparam int CHAN_BITS   = 3;
  localparam int VALUE_BITS  = 16;
  localparam int REF_MV_BITS = 13;
  localparam int WAIT_BITS   = 8;
  localparam int BLOCK_BITS  = 32;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [MODE_BITS-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_DONE  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_BLOCK = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_RSVD  = 2'd3;

  localparam logic [KIND_BITS-1:0] KIND_START  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_CHAN   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_SUPPLY = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_REF_MV = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WAIT   = 1'd1;

  localparam logic [REF_MV_BITS-1:0] REF_MV_RESET = 13'd1200;
  localparam logic [WAIT_BITS-1:0]   WAIT_RESET   = 8'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: rtl/core/adc_scan_vref_ratiometric_top.sv
// Round-robin converter scan with reference-ratiometric millivolt report.
// Depends on asvr_pkg and asvr_div.
//
//   beat     signals                                   direction
//   in       in_valid/in_ready: mode sample block_duration   into block
//   out      out_valid/out_ready: kind channel value_mv saturated last  out of block
//   cfg      cfg_write cfg_index cfg_data              into block, no handshake
//
// An input beat updates timers and samples in its accept cycle. A start result
// is issued from the S_START step, after any report that the same beat triggers.
// A report holds one value per channel plus the supply value; each value is one
// multiply, one divider seed, SAMPLE_BITS+13 divider steps and one divider finish
// step, then one emit step, all on the single shared divider. in_ready is high only
// in idle; a stalled out_ready holds the sequencer at its emit or start step.
// Synchronous reset restores control and timers; sample and result data stay.
module adc_scan_vref_ratiometric_top #(
  parameter int NUM_CHANNELS = 5,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [asvr_pkg::MODE_BITS-1:0]      mode,
  input  logic [SAMPLE_BITS-1:0]              sample,
  input  logic [asvr_pkg::BLOCK_BITS-1:0]     block_duration,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [asvr_pkg::KIND_BITS-1:0]      kind,
  output logic [asvr_pkg::CHAN_BITS-1:0]      channel,
  output logic [asvr_pkg::VALUE_BITS-1:0]     value_mv,
  output logic                                saturated,
  output logic                                last,
  input  logic                                cfg_write,
  input  logic [asvr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [asvr_pkg::REF_MV_BITS-1:0]    cfg_data
);
  import asvr_pkg::*;

  localparam int CH_W  = $clog2(NUM_CHANNELS);
  localparam int IDX_W = $clog2(NUM_CHANNELS + 1);
  localparam int NUM_W = REF_MV_BITS + SAMPLE_BITS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_SEED  = 6'b000100,
    S_DIV   = 6'b001000,
    S_EMIT  = 6'b010000,
    S_START = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [REF_MV_BITS-1:0] ref_mv;
  logic [WAIT_BITS-1:0]   wait_ticks;
  logic [WAIT_BITS-1:0]   wait_timer, wait_next;
  logic [BLOCK_BITS-1:0]  block_timer, block_next;
  logic [CH_W-1:0]        cur, cur_next;
  logic [SAMPLE_BITS-1:0] raw [NUM_CHANNELS];
  logic [IDX_W-1:0]       idx;
  logic                   start_pend;
  logic [NUM_W-1:0]       prod;

  logic                   accept;
  logic                   handled;
  logic                   raw_we;
  logic                   report_next;
  logic                   start_next;
  logic                   out_free;
  logic                   idx_in_range;
  logic [CH_W-1:0]        rd_idx;
  logic [SAMPLE_BITS-1:0] operand;
  logic                   idx_at_end;

  logic [NUM_W-1:0]       quot;
  div_status_t            div_stat;
  logic                   quot_sat;

  assign in_ready     = (state == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign out_free     = !out_valid || out_ready;
  assign idx_in_range = idx < IDX_W'(NUM_CHANNELS);
  assign idx_at_end   = idx == IDX_W'(NUM_CHANNELS);
  assign rd_idx       = idx_in_range ? idx[CH_W-1:0] : '0;
  assign operand      = idx_in_range ? raw[rd_idx] : '1;
  assign quot_sat     = |quot[NUM_W-1:VALUE_BITS];

  asvr_div #(
    .NUM_W(NUM_W),
    .DEN_W(SAMPLE_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_SEED),
    .num   (prod),
    .den   (raw[0]),
    .quot  (quot),
    .status(div_stat)
  );

  always_comb begin
    wait_next   = wait_timer;
    block_next  = block_timer;
    cur_next    = cur;
    raw_we      = 1'b0;
    report_next = 1'b0;
    start_next  = 1'b0;
    handled     = 1'b1;
    unique case (mode)
      MODE_TICK: begin
        if (wait_timer != '0) wait_next = wait_timer - 1'b1;
        if (block_timer != '0) block_next = block_timer - 1'b1;
      end
      MODE_DONE: begin
        if (wait_timer != '0) begin
          wait_next = '0;
          if (block_timer == '0) begin
            raw_we      = 1'b1;
            report_next = (cur == CH_W'(NUM_CHANNELS - 1));
            cur_next    = report_next ? '0 : cur + 1'b1;
          end
        end
      end
      MODE_BLOCK: begin
        block_next = block_duration;
      end
      default: begin
        handled = 1'b0;
      end
    endcase
    if (handled && block_next == '0 && wait_next == '0) begin
      start_next = 1'b1;
      wait_next  = (wait_ticks == '0) ? WAIT_BITS'(1) : wait_ticks;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && handled) begin
          if (report_next) state_next = S_MUL;
          else if (start_next) state_next = S_START;
        end
      end
      S_MUL:  state_next = S_SEED;
      S_SEED: state_next = S_DIV;
      S_DIV: begin
        if (div_stat.done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          if (!idx_at_end) state_next = S_MUL;
          else if (start_pend) state_next = S_START;
          else state_next = S_IDLE;
        end
      end
      S_START: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ref_mv      <= REF_MV_RESET;
      wait_ticks  <= WAIT_RESET;
      wait_timer  <= '0;
      block_timer <= '0;
      cur         <= '0;
      start_pend  <= 1'b0;
      idx         <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_REF_MV: ref_mv <= cfg_data;
          REG_WAIT:   wait_ticks <= cfg_data[WAIT_BITS-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        wait_timer  <= wait_next;
        block_timer <= block_next;
        cur         <= cur_next;
        start_pend  <= start_next;
        idx         <= '0;
      end
      if (state == S_EMIT && out_free && !idx_at_end) idx <= idx + 1'b1;
      if (state == S_START && out_free) start_pend <= 1'b0;
      if ((state == S_EMIT || state == S_START) && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && raw_we) raw[cur] <= sample;
    if (state == S_MUL) prod <= NUM_W'(ref_mv) * NUM_W'(operand);
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      kind      <= idx_in_range ? KIND_CHAN : KIND_SUPPLY;
      channel   <= idx_in_range ? CHAN_BITS'(idx) : '0;
      value_mv  <= quot_sat ? '1 : quot[VALUE_BITS-1:0];
      saturated <= quot_sat;
      last      <= idx_at_end && !start_pend;
    end else if (state == S_START && out_free) begin
      kind      <= KIND_START;
      channel   <= CHAN_BITS'(cur);
      value_mv  <= '0;
      saturated <= 1'b0;
      last      <= 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) div_stat.done |-> state == S_DIV)
    else $error("divider finished outside the divide step");

  assert property (@(posedge clk) disable iff (rst)
    (accept && mode != MODE_RSVD) |=> (wait_timer != '0 || block_timer != '0))
    else $error("handled beat left no conversion pending and no block");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free && idx_at_end) |=> (state == S_START || !start_pend))
    else $error("report ended without issuing the pending start");

endmodule

FILE: rtl/core/asvr_div.sv
// Restoring divider, one quotient bit per cycle, for the scan report.
// Depends on asvr_pkg for the status struct.
module asvr_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  output logic [NUM_W-1:0]     quot,
  output asvr_pkg::div_status_t status
);
  import asvr_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign shifted = {rem, quot[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = shifted >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      rem  <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], ge};
    end
  end

  assign status = '{busy: busy, done: done};

endmodule

FILE: tb/sv/adc_scan_vref_ratiometric_top_tb.sv
// Self-checking testbench for adc_scan_vref_ratiometric_top: scan order, timers, block
// commands and the ratiometric millivolt report, with random stalls on both channels.
// Depends on asvr_pkg and the block's RTL.
module adc_scan_vref_ratiometric_top_tb;
  import asvr_pkg::*;

  localparam int NUM_CH = 5;
  localparam int SBITS = 12;
  localparam logic [SBITS-1:0] SAMPLE_MAX = {SBITS{1'b1}};
  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [CHAN_BITS-1:0]  chan;
    logic [VALUE_BITS-1:0] mv;
    logic                  sat;
    logic                  last;
  } scan_result_t;

  class scan_board;
    bit [REF_MV_BITS-1:0] ref_mv;
    bit [WAIT_BITS-1:0]   wait_ticks;
    bit [CHAN_BITS-1:0]   cur_ch;
    bit [WAIT_BITS-1:0]   wait_tmr;
    bit [BLOCK_BITS-1:0]  block_tmr;
    bit [SBITS-1:0]       raw [NUM_CH];
    scan_result_t         due_q[$];
    int                   errors;

    function new();
      ref_mv = REF_MV_RESET;
      wait_ticks = WAIT_RESET;
      cur_ch = '0;
      wait_tmr = '0;
      block_tmr = '0;
      errors = 0;
      foreach (raw[i]) raw[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [REF_MV_BITS-1:0] data);
      if (idx == REG_REF_MV) ref_mv = data;
      else wait_ticks = data[WAIT_BITS-1:0];
    endfunction

    function void push(logic [KIND_BITS-1:0] k, logic [CHAN_BITS-1:0] ch,
                       logic [VALUE_BITS-1:0] mv, logic sat);
      scan_result_t r;
      r.kind = k;
      r.chan = ch;
      r.mv = mv;
      r.sat = sat;
      r.last = 1'b0;
      due_q.push_back(r);
    endfunction

    function void scale(bit [SBITS-1:0] raw_v, output logic [VALUE_BITS-1:0] mv,
                        output logic sat);
      longint unsigned q;
      if (raw[0] == 0) begin
        mv = '1;
        sat = 1'b1;
      end else begin
        q = (longint'(ref_mv) * longint'(raw_v)) / longint'(raw[0]);
        sat = (q > 65535);
        mv = sat ? '1 : q[VALUE_BITS-1:0];
      end
    endfunction

    function void push_millivolts();
      logic [VALUE_BITS-1:0] mv;
      logic sat;
      for (int i = 0; i < NUM_CH; i++) begin
        scale(raw[i], mv, sat);
        push(KIND_CHAN, i[CHAN_BITS-1:0], mv, sat);
      end
      scale(SAMPLE_MAX, mv, sat);
      push(KIND_SUPPLY, '0, mv, sat);
    endfunction

    function void take_input(logic [MODE_BITS-1:0] m, logic [SBITS-1:0] s,
                             logic [BLOCK_BITS-1:0] d);
      int first;
      scan_result_t tail;
      first = due_q.size();
      if (m == MODE_RSVD) return;
      case (m)
        MODE_TICK: begin
          if (wait_tmr != 0) wait_tmr--;
          if (block_tmr != 0) block_tmr--;
        end
        MODE_DONE: begin
          if (wait_tmr != 0) begin
            wait_tmr = '0;
            if (block_tmr == 0) begin
              raw[cur_ch] = s;
              cur_ch = (cur_ch == NUM_CH - 1) ? '0 : cur_ch + 1'b1;
              if (cur_ch == 0) push_millivolts();
            end
          end
        end
        default: block_tmr = d;
      endcase
      if (block_tmr == 0 && wait_tmr == 0) begin
        push(KIND_START, cur_ch, '0, 1'b0);
        wait_tmr = (wait_ticks == 0) ? 8'd1 : wait_ticks;
      end
      if (due_q.size() > first) begin
        tail = due_q.pop_back();
        tail.last = 1'b1;
        due_q.push_back(tail);
      end
    endfunction

    task log_mismatch(string msg);
      $display("%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(scan_result_t got);
      scan_result_t want;
      if (due_q.size() == 0) begin
        log_mismatch($sformatf("unexpected result beat kind=%0d chan=%0d mv=%0d",
                               got.kind, got.chan, got.mv));
      end else begin
        want = due_q.pop_front();
        if (got.kind !== want.kind)
          log_mismatch($sformatf("kind: got %0d want %0d", got.kind, want.kind));
        if (got.chan !== want.chan)
          log_mismatch($sformatf("channel: got %0d want %0d", got.chan, want.chan));
        if (got.mv !== want.mv)
          log_mismatch($sformatf("value_mv: got %0d want %0d", got.mv, want.mv));
        if (got.sat !== want.sat)
          log_mismatch($sformatf("saturated: got %0d want %0d", got.sat, want.sat));
        if (got.last !== want.last)
          log_mismatch($sformatf("last: got %0d want %0d", got.last, want.last));
      end
    endtask
  endclass

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [MODE_BITS-1:0]    mode;
  logic [SBITS-1:0]        sample;
  logic [BLOCK_BITS-1:0]   block_duration;
  logic                    out_valid;
  logic                    out_ready;
  logic [KIND_BITS-1:0]    kind;
  logic [CHAN_BITS-1:0]    channel;
  logic [VALUE_BITS-1:0]   value_mv;
  logic                    saturated;
  logic                    last;
  logic                    cfg_write;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [REF_MV_BITS-1:0]  cfg_data;

  scan_board sb;
  bit quiet;
  bit beat_taken;
  bit long_hold_req;
  int hold_cnt;

  adc_scan_vref_ratiometric_top #(
    .NUM_CHANNELS(NUM_CH),
    .SAMPLE_BITS (SBITS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .sample        (sample),
    .block_duration(block_duration),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .channel       (channel),
    .value_mv      (value_mv),
    .saturated     (saturated),
    .last          (last),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int draw_stall();
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result('{kind, channel, value_mv, saturated, last});
      beat_taken = 1'b1;
    end
  end

  // out_ready: per-beat stall, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    beat_taken = 1'b0;
    hold_cnt = draw_stall();
    forever begin
      @(negedge clk);
      if (beat_taken) begin
        beat_taken = 1'b0;
        hold_cnt = draw_stall();
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        out_ready = 1'b0;
        hold_cnt--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_beat(logic [MODE_BITS-1:0] m, logic [SBITS-1:0] s,
                           logic [BLOCK_BITS-1:0] d);
    int gap;
    gap = draw_stall();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    mode = m;
    sample = s;
    block_duration = d;
    do @(posedge clk); while (!in_ready);
    sb.take_input(m, s, d);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [REF_MV_BITS-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int n);
    int sent;
    int pick;
    logic [MODE_BITS-1:0] m;
    logic [SBITS-1:0] s;
    logic [BLOCK_BITS-1:0] d;
    sent = 0;
    quiet = ($urandom_range(0, 3) == 0);
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) m = MODE_DONE;
      else if (pick < 82) m = MODE_TICK;
      else if (pick < 94) m = MODE_BLOCK;
      else m = MODE_RSVD;
      case ($urandom_range(0, 9))
        0: s = '0;
        1: s = SAMPLE_MAX;
        default: s = SBITS'($urandom_range(0, 4095));
      endcase
      d = $urandom;
      if (m == MODE_BLOCK) begin
        case ($urandom_range(0, 7)) inside
          0, 1: d = '0;
          2: d = $urandom;
          default: d = $urandom_range(1, 6);
        endcase
      end
      send_beat(m, s, d);
      if (m != MODE_RSVD) sent++;
      if (sent % 20 == 0) quiet = ($urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_TICK;
    sample = '0;
    block_duration = '0;
    cfg_write = 1'b0;
    cfg_index = REG_REF_MV;
    cfg_data = '0;
    quiet = 1'b0;
    long_hold_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(REG_REF_MV, 13'd1200);
    write_reg(REG_WAIT, 13'd2);
    // zero reference pass, reserved mode, wait expiry restart
    send_beat(MODE_TICK, '0, '0);
    send_beat(MODE_RSVD, SAMPLE_MAX, '1);
    send_beat(MODE_DONE, '0, '0);
    send_beat(MODE_DONE, SAMPLE_MAX, '0);
    send_beat(MODE_DONE, 12'd1, '0);
    send_beat(MODE_DONE, 12'd2048, '0);
    send_beat(MODE_DONE, SAMPLE_MAX, '0);
    send_beat(MODE_TICK, '0, '0);
    send_beat(MODE_TICK, '0, '0);
    // reference of one: saturation edge at 54 and 55
    send_beat(MODE_DONE, 12'd1, '0);
    send_beat(MODE_DONE, SAMPLE_MAX, '0);
    send_beat(MODE_DONE, '0, '0);
    send_beat(MODE_DONE, 12'd54, '0);
    send_beat(MODE_DONE, 12'd55, '0);
    // block while pending, done while blocked, idle done
    send_beat(MODE_BLOCK, '0, 32'd3);
    send_beat(MODE_DONE, 12'd7, '0);
    send_beat(MODE_DONE, 12'd9, '0);
    send_beat(MODE_TICK, '0, '0);
    send_beat(MODE_TICK, '0, '0);
    send_beat(MODE_TICK, '0, '0);
    send_beat(MODE_BLOCK, '0, '1);
    send_beat(MODE_BLOCK, '0, '0);
    send_beat(MODE_DONE, SAMPLE_MAX, '0);
    drain();

    write_reg(REG_REF_MV, 13'd5000);
    write_reg(REG_WAIT, 13'd0);
    send_beat(MODE_TICK, '0, '0);
    send_beat(MODE_TICK, '0, '0);
    run_random(40);
    drain();

    write_reg(REG_REF_MV, 13'd1);
    write_reg(REG_WAIT, 13'd255);
    run_random(45);
    drain();

    write_reg(REG_REF_MV, 13'd8191);
    write_reg(REG_WAIT, 13'd1);
    long_hold_req = 1'b1;
    run_random(50);
    drain();

    write_reg(REG_REF_MV, 13'd0);
    write_reg(REG_WAIT, 13'd3);
    run_random(35);
    drain();

    write_reg(REG_REF_MV, 13'($urandom_range(1, 5000)));
    write_reg(REG_WAIT, 13'($urandom_range(1, 8)));
    long_hold_req = 1'b1;
    run_random(50);
    drain();

    write_reg(REG_REF_MV, 13'd5000);
    write_reg(REG_WAIT, 13'($urandom_range(1, 4)));
    run_random(40);
    drain();

    write_reg(REG_REF_MV, 13'($urandom));
    write_reg(REG_WAIT, 13'($urandom_range(0, 255)));
    run_random(40);
    drain();

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/core/asvr_pkg.sv
rtl/core/asvr_div.sv
rtl/core/adc_scan_vref_ratiometric_top.sv
tb/sv/adc_scan_vref_ratiometric_top_tb.sv
